// ----- rtl/mlrq_pkg.sv -----
package mlrq_pkg;

    // Fixed field widths of the request and response transactions.
    localparam int PID_W    = 5;
    localparam int MODE_W   = 2;
    localparam int PRIO_W   = 2;
    localparam int STATUS_W = 2;

    // Operation codes carried in the mode field.
    typedef enum logic [MODE_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_PICK    = 2'd1,
        OP_REMOVE  = 2'd2
    } mode_t;

    // Completion status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NOT_QUEUED = 2'd1,
        ST_ALREADY    = 2'd2
    } status_t;

endpackage

// ----- rtl/mlrq_if.sv -----
// Request channel: one scheduler operation per transaction.
interface mlrq_req_if;
    logic                             valid;
    logic                             ready;
    logic [mlrq_pkg::MODE_W-1:0]      mode;
    logic [mlrq_pkg::PID_W-1:0]       process_id;
    logic [mlrq_pkg::PRIO_W-1:0]      priority_level;

    modport source (output valid, output mode, output process_id,
                    output priority_level, input ready);
    modport sink   (input valid, input mode, input process_id,
                    input priority_level, output ready);
endinterface

// Response channel: one result per request transaction.
interface mlrq_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [mlrq_pkg::PID_W-1:0]       chosen_process;
    logic                             went_idle;
    logic [mlrq_pkg::STATUS_W-1:0]    status;

    modport source (output valid, output chosen_process, output went_idle,
                    output status, input ready);
    modport sink   (input valid, input chosen_process, input went_idle,
                    input status, output ready);
endinterface

// ----- rtl/mlrq_ram.sv -----
// Single-port RAM with registered read data.
module mlrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read of the addressed entry.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/multilevel_ready_queue.sv -----
// Flow: a request is taken in S_IDLE and decoded in S_EXEC; paths that patch links (enqueue
// onto a non-empty level, pick or remove of a queued slot) pass S_LINK or S_UNLINK, then
// S_FINISH registers the result once the response is free. No new request is taken before
// that hand-off; each link RAM has one port, so reads and neighbor writes take turns.
// Reset (rst_n, asynchronous): all levels empty, idle slot not ready, no result
// pending; the link RAMs are not cleared and need no clearing pass.
module multilevel_ready_queue #(
    parameter int NUM_SLOTS  = 32,
    parameter int NUM_LEVELS = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    mlrq_req_if.sink       req,
    mlrq_rsp_if.source     rsp
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int LINK_W = $clog2(NUM_SLOTS + 1);
    localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LINK,
        S_UNLINK,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    // Captured request and the slot being worked on.
    mlrq_pkg::mode_t                mode_reg, mode_next;
    logic [mlrq_pkg::PID_W-1:0]     pid_reg, pid_next;
    logic [LVL_W-1:0]               lvl_reg, lvl_next;
    logic [SLOT_W-1:0]              slot_reg, slot_next;

    // Result under construction.
    logic [mlrq_pkg::PID_W-1:0]     res_chosen_reg, res_chosen_next;
    logic                           res_idle_reg, res_idle_next;
    mlrq_pkg::status_t              res_status_reg, res_status_next;

    // Output register.
    logic                           rsp_valid_reg, rsp_valid_next;
    logic [mlrq_pkg::PID_W-1:0]     rsp_chosen_reg, rsp_chosen_next;
    logic                           rsp_idle_reg, rsp_idle_next;
    mlrq_pkg::status_t              rsp_status_reg, rsp_status_next;

    // Queue bookkeeping.
    logic [SLOT_W-1:0]              head_reg [NUM_LEVELS];
    logic [SLOT_W-1:0]              head_next [NUM_LEVELS];
    logic [SLOT_W-1:0]              tail_reg [NUM_LEVELS];
    logic [SLOT_W-1:0]              tail_next [NUM_LEVELS];
    logic [NUM_LEVELS-1:0]          nonempty_reg, nonempty_next;
    logic [NUM_SLOTS-1:0]           queued_reg, queued_next;
    logic                           idle_ready_reg, idle_ready_next;

    // Link and level RAM ports.
    logic                           nl_we, pl_we, lv_we;
    logic [SLOT_W-1:0]              nl_addr, pl_addr, lv_addr;
    logic [LINK_W-1:0]              nl_wdata, pl_wdata, nl_rdata, pl_rdata;
    logic [LVL_W-1:0]               lv_wdata, lv_rdata;

    // Decoded helpers.
    logic [LVL_W-1:0]               req_lvl_sat;
    logic [SLOT_W-1:0]              pid_slot;
    logic                           pid_in_range;
    logic                           pid_queued;
    logic [LVL_W-1:0]               top_lvl;
    logic                           any_nonempty;
    logic [SLOT_W-1:0]              exec_addr;
    logic                           prev_valid, next_valid;
    logic                           rsp_free;

    mlrq_ram #(.WIDTH(LINK_W), .DEPTH(NUM_SLOTS)) u_next_ram (
        .clk   (clk),
        .we    (nl_we),
        .addr  (nl_addr),
        .wdata (nl_wdata),
        .rdata (nl_rdata)
    );

    mlrq_ram #(.WIDTH(LINK_W), .DEPTH(NUM_SLOTS)) u_prev_ram (
        .clk   (clk),
        .we    (pl_we),
        .addr  (pl_addr),
        .wdata (pl_wdata),
        .rdata (pl_rdata)
    );

    mlrq_ram #(.WIDTH(LVL_W), .DEPTH(NUM_SLOTS)) u_level_ram (
        .clk   (clk),
        .we    (lv_we),
        .addr  (lv_addr),
        .wdata (lv_wdata),
        .rdata (lv_rdata)
    );

    // Saturate the requested level to the levels that exist.
    assign req_lvl_sat = (32'(req.priority_level) >= NUM_LEVELS)
                         ? LVL_W'(NUM_LEVELS - 1) : LVL_W'(req.priority_level);

    assign pid_slot     = SLOT_W'(pid_reg);
    assign pid_in_range = (32'(pid_reg) < NUM_SLOTS);
    assign pid_queued   = pid_in_range && queued_reg[pid_slot];

    // Highest non-empty level; the later match wins.
    always_comb
    begin
        top_lvl = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (nonempty_reg[i])
            begin
                top_lvl = LVL_W'(i);
            end
        end
    end

    assign any_nonempty = |nonempty_reg;
    assign exec_addr    = (mode_reg == mlrq_pkg::OP_PICK) ? head_reg[top_lvl] : pid_slot;
    assign prev_valid   = (pl_rdata != LINK_NONE);
    assign next_valid   = (nl_rdata != LINK_NONE);
    assign rsp_free     = !rsp_valid_reg || rsp.ready;

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.chosen_process = rsp_chosen_reg;
    assign rsp.went_idle      = rsp_idle_reg;
    assign rsp.status         = rsp_status_reg;

    // Sequencer: decode, link RAM writes, unlink, and result hand-off.
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        pid_next        = pid_reg;
        lvl_next        = lvl_reg;
        slot_next       = slot_reg;
        res_chosen_next = res_chosen_reg;
        res_idle_next   = res_idle_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_chosen_next = rsp_chosen_reg;
        rsp_idle_next   = rsp_idle_reg;
        rsp_status_next = rsp_status_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        nonempty_next   = nonempty_reg;
        queued_next     = queued_reg;
        idle_ready_next = idle_ready_reg;

        nl_we    = 1'b0;
        pl_we    = 1'b0;
        lv_we    = 1'b0;
        nl_addr  = exec_addr;
        pl_addr  = exec_addr;
        lv_addr  = exec_addr;
        nl_wdata = LINK_NONE;
        pl_wdata = LINK_NONE;
        lv_wdata = lvl_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next  = mlrq_pkg::mode_t'(req.mode);
                    pid_next   = req.process_id;
                    lvl_next   = req_lvl_sat;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_chosen_next = pid_reg;
                res_idle_next   = 1'b0;
                res_status_next = mlrq_pkg::ST_OK;
                state_next      = S_FINISH;
                case (mode_reg)
                    mlrq_pkg::OP_ENQUEUE:
                    begin
                        if (pid_reg == '0)
                        begin
                            // The idle slot only carries a ready mark.
                            if (idle_ready_reg)
                            begin
                                res_status_next = mlrq_pkg::ST_ALREADY;
                            end
                            idle_ready_next = 1'b1;
                        end
                        else if (!pid_in_range)
                        begin
                            res_status_next = mlrq_pkg::ST_NOT_QUEUED;
                        end
                        else if (pid_queued)
                        begin
                            res_status_next = mlrq_pkg::ST_ALREADY;
                        end
                        else
                        begin
                            // New tail: no successor, predecessor is the old tail, if any.
                            slot_next              = pid_slot;
                            nl_we                  = 1'b1;
                            pl_we                  = 1'b1;
                            lv_we                  = 1'b1;
                            pl_wdata               = nonempty_reg[lvl_reg]
                                                     ? LINK_W'(tail_reg[lvl_reg]) : LINK_NONE;
                            queued_next[pid_slot]  = 1'b1;
                            if (nonempty_reg[lvl_reg])
                            begin
                                state_next = S_LINK;
                            end
                            else
                            begin
                                head_next[lvl_reg]     = pid_slot;
                                tail_next[lvl_reg]     = pid_slot;
                                nonempty_next[lvl_reg] = 1'b1;
                            end
                        end
                    end

                    mlrq_pkg::OP_PICK:
                    begin
                        if (any_nonempty)
                        begin
                            // Links of the head come back next cycle.
                            res_chosen_next = mlrq_pkg::PID_W'(head_reg[top_lvl]);
                            slot_next       = head_reg[top_lvl];
                            state_next      = S_UNLINK;
                        end
                        else
                        begin
                            res_chosen_next = '0;
                            res_idle_next   = 1'b1;
                            idle_ready_next = 1'b0;
                        end
                    end

                    mlrq_pkg::OP_REMOVE:
                    begin
                        if (pid_reg == '0)
                        begin
                            if (!idle_ready_reg)
                            begin
                                res_status_next = mlrq_pkg::ST_NOT_QUEUED;
                            end
                            idle_ready_next = 1'b0;
                        end
                        else if (!pid_queued)
                        begin
                            res_status_next = mlrq_pkg::ST_NOT_QUEUED;
                        end
                        else
                        begin
                            slot_next  = pid_slot;
                            state_next = S_UNLINK;
                        end
                    end

                    default:
                    begin
                    end
                endcase
            end

            S_LINK:
            begin
                // Point the old tail forward at the new slot.
                nl_we              = 1'b1;
                nl_addr            = tail_reg[lvl_reg];
                nl_wdata           = LINK_W'(slot_reg);
                tail_next[lvl_reg] = slot_reg;
                state_next         = S_FINISH;
            end

            S_UNLINK:
            begin
                // Bridge the neighbors, or move the head and tail of the level.
                if (prev_valid)
                begin
                    nl_we    = 1'b1;
                    nl_addr  = SLOT_W'(pl_rdata);
                    nl_wdata = nl_rdata;
                end
                else
                begin
                    head_next[lv_rdata] = next_valid ? SLOT_W'(nl_rdata) : '0;
                end
                if (next_valid)
                begin
                    pl_we    = 1'b1;
                    pl_addr  = SLOT_W'(nl_rdata);
                    pl_wdata = pl_rdata;
                end
                else
                begin
                    tail_next[lv_rdata] = prev_valid ? SLOT_W'(pl_rdata) : '0;
                end
                if (!prev_valid && !next_valid)
                begin
                    nonempty_next[lv_rdata] = 1'b0;
                end
                queued_next[slot_reg] = 1'b0;
                state_next            = S_FINISH;
            end

            S_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_chosen_next = res_chosen_reg;
                    rsp_idle_next   = res_idle_reg;
                    rsp_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, queue bookkeeping and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rsp_valid_reg  <= 1'b0;
            nonempty_reg   <= '0;
            queued_reg     <= '0;
            idle_ready_reg <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
            nonempty_reg   <= nonempty_next;
            queued_reg     <= queued_next;
            idle_ready_reg <= idle_ready_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        pid_reg        <= pid_next;
        lvl_reg        <= lvl_next;
        slot_reg       <= slot_next;
        res_chosen_reg <= res_chosen_next;
        res_idle_reg   <= res_idle_next;
        res_status_reg <= res_status_next;
        rsp_chosen_reg <= rsp_chosen_next;
        rsp_idle_reg   <= rsp_idle_next;
        rsp_status_reg <= rsp_status_next;
    end

endmodule

// ----- rtl/mlrq_checker.sv -----
// Port-level checks on the ready queue.
module mlrq_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic [mlrq_pkg::PID_W-1:0]       rsp_chosen_process,
    input logic                             rsp_went_idle,
    input logic [mlrq_pkg::STATUS_W-1:0]    rsp_status
);

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response valid dropped before its transaction");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_chosen_process) && $stable(rsp_went_idle)
                                    && $stable(rsp_status))
    else $error("response payload changed while stalled");

    // An idle pick always names the idle slot and succeeds.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_went_idle |-> rsp_chosen_process == '0
                                       && rsp_status == mlrq_pkg::ST_OK)
    else $error("idle result with wrong slot or status");

    // The block works on one request at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous one still in work");

endmodule

bind multilevel_ready_queue mlrq_checker u_mlrq_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_chosen_process (rsp.chosen_process),
    .rsp_went_idle      (rsp.went_idle),
    .rsp_status         (rsp.status)
);
